### rtl/rqt_pkg.sv
// ----------------------------------------------------------------------------
// rqt_pkg
// Shared codes, defaults and control types of the replica quorum tracker.
// ----------------------------------------------------------------------------
package rqt_pkg;

   // default sizes
   localparam int DEF_TABLE_DEPTH   = 16;
   localparam int DEF_TRANS_ID_BITS = 16;
   localparam int DEF_VALUE_BITS    = 32;

   // fixed field widths
   localparam int CMD_BITS       = 2;
   localparam int KIND_BITS      = 2;
   localparam int OUTCOME_BITS   = 2;
   localparam int TIME_BITS      = 32;
   localparam int TIMEOUT_BITS   = 16;
   localparam int COUNT_BITS     = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // request commands
   localparam logic [CMD_BITS-1:0] CMD_START = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_REPLY = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_TICK  = 2'd2;

   // operation kinds
   localparam logic [KIND_BITS-1:0] KIND_CREATE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_UPDATE = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_DELETE = 2'd3;

   // outcomes
   localparam logic [OUTCOME_BITS-1:0] OUT_SUCCESS = 2'd0;
   localparam logic [OUTCOME_BITS-1:0] OUT_FAILED  = 2'd1;
   localparam logic [OUTCOME_BITS-1:0] OUT_TIMEOUT = 2'd2;
   localparam logic [OUTCOME_BITS-1:0] OUT_FULL    = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUORUM  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPLICA = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAIL    = 2'd3;

   // register reset values
   localparam logic [TIMEOUT_BITS-1:0] RST_TIMEOUT = 16'd10;
   localparam logic [COUNT_BITS-1:0]   RST_QUORUM  = 2'd2;
   localparam logic [COUNT_BITS-1:0]   RST_REPLICA = 2'd3;
   localparam logic [COUNT_BITS-1:0]   RST_FAIL    = 2'd2;

   // tag table lookup status
   typedef struct packed {
      logic hit;
      logic free_found;
   } cam_status_type;

   // tag table write command
   typedef struct packed {
      logic set;
      logic clr;
   } cam_cmd_type;

endpackage

### rtl/replica_quorum_tracker.sv
// ----------------------------------------------------------------------------
// replica_quorum_tracker
// Table of outstanding replicated operations: opens entries on start,
// counts replica replies against quorum limits, fails stale entries on tick.
// ----------------------------------------------------------------------------
// Start and reply requests do the lookup and entry read in the accept cycle
// and the read-modify-write in the next; a result strobes in the cycle after.
// A tick sweeps one entry per cycle, then takes a flush step; a timeout result
// waits for the next expiry or the flush step before it is registered to strobe.
// The receiver cannot stall. Reset clears all valid bits, loads register
// defaults and returns to idle; entry memory contents are not cleared.
module replica_quorum_tracker #(
   parameter int TABLE_DEPTH   = rqt_pkg::DEF_TABLE_DEPTH,
   parameter int TRANS_ID_BITS = rqt_pkg::DEF_TRANS_ID_BITS,
   parameter int VALUE_BITS    = rqt_pkg::DEF_VALUE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic [rqt_pkg::CMD_BITS-1:0]         req_cmd,
   input  logic [TRANS_ID_BITS-1:0]             req_trans_id,
   input  logic [rqt_pkg::KIND_BITS-1:0]        req_op_kind,
   input  logic [rqt_pkg::TIME_BITS-1:0]        req_now_time,
   input  logic                                 req_reply_ok,
   input  logic                                 req_reply_has_value,
   input  logic [TRANS_ID_BITS-1:0]             req_reply_version,
   input  logic [VALUE_BITS-1:0]                req_reply_value,
   // result channel
   output logic                                 rsp_strobe,
   output logic [TRANS_ID_BITS-1:0]             rsp_done_trans_id,
   output logic [rqt_pkg::KIND_BITS-1:0]        rsp_done_kind,
   output logic [rqt_pkg::OUTCOME_BITS-1:0]     rsp_outcome,
   output logic [VALUE_BITS-1:0]                rsp_best_value,
   output logic                                 rsp_last_of_run,
   // configuration port
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rqt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rqt_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [rqt_pkg::KIND_BITS-1:0]  kind;
      logic [rqt_pkg::TIME_BITS-1:0]  start_time;
      logic [rqt_pkg::COUNT_BITS-1:0] ok_count;
      logic [rqt_pkg::COUNT_BITS-1:0] fail_count;
      logic                           best_seen;
      logic [TRANS_ID_BITS-1:0]       best_version;
      logic [VALUE_BITS-1:0]          best_value;
   } entry_type;

   function automatic logic [rqt_pkg::COUNT_BITS-1:0] bump(
      input logic [rqt_pkg::COUNT_BITS-1:0] c
   );
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // configuration registers
   logic [rqt_pkg::TIMEOUT_BITS-1:0] timeout_ff;
   logic [rqt_pkg::COUNT_BITS-1:0]   quorum_ff;
   logic [rqt_pkg::COUNT_BITS-1:0]   replica_ff;
   logic [rqt_pkg::COUNT_BITS-1:0]   fail_limit_ff;

   // latched request
   logic [rqt_pkg::CMD_BITS-1:0]  req_cmd_ff;
   logic [TRANS_ID_BITS-1:0]      req_trans_id_ff;
   logic [rqt_pkg::KIND_BITS-1:0] req_op_kind_ff;
   logic [rqt_pkg::TIME_BITS-1:0] req_now_time_ff;
   logic                          req_reply_ok_ff;
   logic                          req_has_value_ff;
   logic [TRANS_ID_BITS-1:0]      req_version_ff;
   logic [VALUE_BITS-1:0]         req_value_ff;
   rqt_pkg::cam_status_type       lookup_ff;
   logic [AW-1:0]                 hit_idx_ff;
   logic [AW-1:0]                 free_idx_ff;

   // control
   state_type                     state_ff, state_in;
   logic [AW-1:0]                 eval_idx_ff, eval_idx_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [TRANS_ID_BITS-1:0]      pend_trans_id_ff, pend_trans_id_in;
   logic [rqt_pkg::KIND_BITS-1:0] pend_kind_ff, pend_kind_in;

   // registered result
   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [TRANS_ID_BITS-1:0]          rsp_trans_id_ff, rsp_trans_id_in;
   logic [rqt_pkg::KIND_BITS-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [rqt_pkg::OUTCOME_BITS-1:0]  rsp_outcome_ff, rsp_outcome_in;
   logic [VALUE_BITS-1:0]             rsp_value_ff, rsp_value_in;
   logic                              rsp_last_ff, rsp_last_in;

   // entry memory
   entry_type     entry_mem [TABLE_DEPTH];
   entry_type     rd_data_ff;
   logic [AW-1:0] mem_raddr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;

   // tag table
   rqt_pkg::cam_status_type  lookup;
   logic [AW-1:0]            hit_idx;
   logic [AW-1:0]            free_idx;
   logic                     scan_valid;
   logic [TRANS_ID_BITS-1:0] scan_tag;
   rqt_pkg::cam_cmd_type     cam_cmd;
   logic [AW-1:0]            cam_idx;

   // reply evaluation
   entry_type                        upd;
   logic                             reply_done;
   logic [rqt_pkg::OUTCOME_BITS-1:0] reply_outcome;
   logic [VALUE_BITS-1:0]            reply_value;
   logic                             expired;
   logic                             accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;

   // ------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= rqt_pkg::RST_TIMEOUT;
         quorum_ff     <= rqt_pkg::RST_QUORUM;
         replica_ff    <= rqt_pkg::RST_REPLICA;
         fail_limit_ff <= rqt_pkg::RST_FAIL;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rqt_pkg::CSR_TIMEOUT: timeout_ff    <= csr_wdata;
            rqt_pkg::CSR_QUORUM:  quorum_ff     <= csr_wdata[rqt_pkg::COUNT_BITS-1:0];
            rqt_pkg::CSR_REPLICA: replica_ff    <= csr_wdata[rqt_pkg::COUNT_BITS-1:0];
            rqt_pkg::CSR_FAIL:    fail_limit_ff <= csr_wdata[rqt_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // tag table
   // ------------------------------------------------------------------
   rqt_tag_cam #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .TRANS_ID_BITS (TRANS_ID_BITS)
   ) u_cam (
      .clock      (clock),
      .reset      (reset),
      .lookup_tag (req_trans_id),
      .lookup     (lookup),
      .hit_idx    (hit_idx),
      .free_idx   (free_idx),
      .scan_idx   (eval_idx_ff),
      .scan_valid (scan_valid),
      .scan_tag   (scan_tag),
      .wr_cmd     (cam_cmd),
      .wr_idx     (cam_idx),
      .wr_tag     (req_trans_id_ff)
   );

   // ------------------------------------------------------------------
   // entry memory
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[mem_raddr];
   end

   always_comb begin
      case (state_ff)
         ST_IDLE:  mem_raddr = (req_cmd == rqt_pkg::CMD_TICK) ? '0 : hit_idx;
         ST_SCAN:  mem_raddr = (eval_idx_ff == LAST_IDX) ? eval_idx_ff
                                                         : eval_idx_ff + 1'b1;
         default:  mem_raddr = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // reply update of the entry read in the accept cycle
   // ------------------------------------------------------------------
   always_comb begin
      upd           = rd_data_ff;
      reply_done    = 1'b0;
      reply_outcome = rqt_pkg::OUT_SUCCESS;
      reply_value   = '0;
      case (rd_data_ff.kind)
         rqt_pkg::KIND_CREATE: begin
            upd.ok_count = bump(rd_data_ff.ok_count);
            reply_done   = (upd.ok_count >= quorum_ff);
         end
         rqt_pkg::KIND_DELETE: begin
            if (req_reply_ok_ff) begin
               upd.ok_count = bump(rd_data_ff.ok_count);
               reply_done   = (upd.ok_count >= replica_ff);
            end else begin
               reply_done    = 1'b1;
               reply_outcome = rqt_pkg::OUT_FAILED;
            end
         end
         rqt_pkg::KIND_READ: begin
            if (req_has_value_ff) begin
               upd.ok_count = bump(rd_data_ff.ok_count);
               // keep the first value or a strictly newer version
               if (!rd_data_ff.best_seen || req_version_ff > rd_data_ff.best_version) begin
                  upd.best_seen    = 1'b1;
                  upd.best_version = req_version_ff;
                  upd.best_value   = req_value_ff;
               end
               if (upd.ok_count >= quorum_ff) begin
                  reply_done  = 1'b1;
                  reply_value = upd.best_value;
               end
            end else begin
               upd.fail_count = bump(rd_data_ff.fail_count);
               if (upd.fail_count >= fail_limit_ff) begin
                  reply_done    = 1'b1;
                  reply_outcome = rqt_pkg::OUT_FAILED;
               end
            end
         end
         default: begin
            if (req_reply_ok_ff) begin
               upd.ok_count = bump(rd_data_ff.ok_count);
               reply_done   = (upd.ok_count >= quorum_ff);
            end else begin
               upd.fail_count = bump(rd_data_ff.fail_count);
               if (upd.fail_count >= fail_limit_ff) begin
                  reply_done    = 1'b1;
                  reply_outcome = rqt_pkg::OUT_FAILED;
               end
            end
         end
      endcase
   end

   // elapsed time wraps modulo the time width
   assign expired = scan_valid &&
      ((req_now_time_ff - rd_data_ff.start_time) >
       {{(rqt_pkg::TIME_BITS - rqt_pkg::TIMEOUT_BITS){1'b0}}, timeout_ff});

   // ------------------------------------------------------------------
   // next state, memory and tag writes, results
   // ------------------------------------------------------------------
   always_comb begin
      state_in         = state_ff;
      eval_idx_in      = eval_idx_ff;
      pend_valid_in    = pend_valid_ff;
      pend_trans_id_in = pend_trans_id_ff;
      pend_kind_in     = pend_kind_ff;
      rsp_strobe_in    = 1'b0;
      rsp_trans_id_in  = rsp_trans_id_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_outcome_in   = rsp_outcome_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_last_in      = rsp_last_ff;
      mem_we           = 1'b0;
      mem_waddr        = hit_idx_ff;
      mem_wdata        = upd;
      cam_cmd          = '0;
      cam_idx          = hit_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               eval_idx_in = '0;
               state_in    = (req_cmd == rqt_pkg::CMD_TICK) ? ST_SCAN : ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_IDLE;
            case (req_cmd_ff)
               rqt_pkg::CMD_START: begin
                  if (!lookup_ff.hit) begin
                     if (lookup_ff.free_found) begin
                        cam_cmd.set           = 1'b1;
                        cam_idx               = free_idx_ff;
                        mem_we                = 1'b1;
                        mem_waddr             = free_idx_ff;
                        mem_wdata             = '0;
                        mem_wdata.kind        = req_op_kind_ff;
                        mem_wdata.start_time  = req_now_time_ff;
                     end else begin
                        rsp_strobe_in   = 1'b1;
                        rsp_trans_id_in = req_trans_id_ff;
                        rsp_kind_in     = req_op_kind_ff;
                        rsp_outcome_in  = rqt_pkg::OUT_FULL;
                        rsp_value_in    = '0;
                        rsp_last_in     = 1'b1;
                     end
                  end
               end
               rqt_pkg::CMD_REPLY: begin
                  if (lookup_ff.hit) begin
                     mem_we = 1'b1;
                     if (reply_done) begin
                        cam_cmd.clr     = 1'b1;
                        rsp_strobe_in   = 1'b1;
                        rsp_trans_id_in = req_trans_id_ff;
                        rsp_kind_in     = rd_data_ff.kind;
                        rsp_outcome_in  = reply_outcome;
                        rsp_value_in    = reply_value;
                        rsp_last_in     = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end

         ST_SCAN: begin
            cam_idx = eval_idx_ff;
            if (expired) begin
               cam_cmd.clr = 1'b1;
               // hold one result back so the final one can be marked last
               if (pend_valid_ff) begin
                  rsp_strobe_in   = 1'b1;
                  rsp_trans_id_in = pend_trans_id_ff;
                  rsp_kind_in     = pend_kind_ff;
                  rsp_outcome_in  = rqt_pkg::OUT_TIMEOUT;
                  rsp_value_in    = '0;
                  rsp_last_in     = 1'b0;
               end
               pend_valid_in    = 1'b1;
               pend_trans_id_in = scan_tag;
               pend_kind_in     = rd_data_ff.kind;
            end
            if (eval_idx_ff == LAST_IDX) begin
               state_in = ST_FLUSH;
            end else begin
               eval_idx_in = eval_idx_ff + 1'b1;
            end
         end

         ST_FLUSH: begin
            state_in      = ST_IDLE;
            pend_valid_in = 1'b0;
            if (pend_valid_ff) begin
               rsp_strobe_in   = 1'b1;
               rsp_trans_id_in = pend_trans_id_ff;
               rsp_kind_in     = pend_kind_ff;
               rsp_outcome_in  = rqt_pkg::OUT_TIMEOUT;
               rsp_value_in    = '0;
               rsp_last_in     = 1'b1;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      eval_idx_ff      <= eval_idx_in;
      pend_trans_id_ff <= pend_trans_id_in;
      pend_kind_ff     <= pend_kind_in;
      rsp_trans_id_ff  <= rsp_trans_id_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_outcome_ff   <= rsp_outcome_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_last_ff      <= rsp_last_in;
   end

   // latch the request and its lookup at accept
   always_ff @(posedge clock) begin
      if (accept) begin
         req_cmd_ff       <= req_cmd;
         req_trans_id_ff  <= req_trans_id;
         req_op_kind_ff   <= req_op_kind;
         req_now_time_ff  <= req_now_time;
         req_reply_ok_ff  <= req_reply_ok;
         req_has_value_ff <= req_reply_has_value;
         req_version_ff   <= req_reply_version;
         req_value_ff     <= req_reply_value;
         lookup_ff        <= lookup;
         hit_idx_ff       <= hit_idx;
         free_idx_ff      <= free_idx;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_done_trans_id = rsp_trans_id_ff;
   assign rsp_done_kind     = rsp_kind_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_best_value    = rsp_value_ff;
   assign rsp_last_of_run   = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // a value is reported only with a successful read
   a_value_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !(rsp_outcome_ff == rqt_pkg::OUT_SUCCESS &&
                         rsp_kind_ff == rqt_pkg::KIND_READ) |-> rsp_value_ff == '0)
      else $error("result value set outside read success");

   // start and reply produce a single result, always marked last
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_outcome_ff != rqt_pkg::OUT_TIMEOUT |-> rsp_last_ff)
      else $error("non-timeout result not marked last");

   // the last timeout result of a tick comes from the flush step
   a_tick_last_from_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_outcome_ff == rqt_pkg::OUT_TIMEOUT && rsp_last_ff
      |-> $past(state_ff == ST_FLUSH))
      else $error("last timeout result outside flush");

   // a held-back timeout result exists only during a tick
   a_pend_in_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> state_ff == ST_SCAN || state_ff == ST_FLUSH)
      else $error("pending timeout result outside tick");

   // an accepted request always takes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting a request");
`endif

endmodule

### rtl/rqt_tag_cam.sv
// ----------------------------------------------------------------------------
// rqt_tag_cam
// Valid bits and transaction tags of the table, with id match, lowest free
// entry search and a per-entry read port for the timeout scan.
// ----------------------------------------------------------------------------
module rqt_tag_cam #(
   parameter int TABLE_DEPTH   = rqt_pkg::DEF_TABLE_DEPTH,
   parameter int TRANS_ID_BITS = rqt_pkg::DEF_TRANS_ID_BITS,
   localparam int AW           = $clog2(TABLE_DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [TRANS_ID_BITS-1:0]   lookup_tag,
   output rqt_pkg::cam_status_type    lookup,
   output logic [AW-1:0]              hit_idx,
   output logic [AW-1:0]              free_idx,
   input  logic [AW-1:0]              scan_idx,
   output logic                       scan_valid,
   output logic [TRANS_ID_BITS-1:0]   scan_tag,
   input  rqt_pkg::cam_cmd_type       wr_cmd,
   input  logic [AW-1:0]              wr_idx,
   input  logic [TRANS_ID_BITS-1:0]   wr_tag
);

   logic [TABLE_DEPTH-1:0]   valid_ff;
   logic [TRANS_ID_BITS-1:0] tag_ff [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_cmd.set) begin
         valid_ff[wr_idx] <= 1'b1;
      end else if (wr_cmd.clr) begin
         valid_ff[wr_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cmd.set) begin
         tag_ff[wr_idx] <= wr_tag;
      end
   end

   // walk down so the lowest matching or free entry wins
   always_comb begin
      lookup   = '0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == lookup_tag) begin
            lookup.hit = 1'b1;
            hit_idx    = AW'(i);
         end
         if (!valid_ff[i]) begin
            lookup.free_found = 1'b1;
            free_idx          = AW'(i);
         end
      end
   end

   assign scan_valid = valid_ff[scan_idx];
   assign scan_tag   = tag_ff[scan_idx];

endmodule
